### src/gf8bf_pkg.sv
// gf8bf_pkg: shared types, register indexes and gf(2) helper functions
// for the radix-8 additive-fft butterfly; depends on nothing
`default_nettype none

package gf8bf_pkg;

    localparam int SHARD_W   = 8;
    localparam int NUM_SHARD = 8;
    localparam int MAT_W     = 64;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAIR01   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR23   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR45   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR67   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MID_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MID_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOP      = 3'd6;

    typedef logic [SHARD_W-1:0]                byte_t;
    typedef logic [MAT_W-1:0]                  mat_t;
    typedef logic [NUM_SHARD-1:0][SHARD_W-1:0] shard_vec_t;

    // product of a column-major 8x8 bit matrix and a byte
    function automatic byte_t gf2_matmul(input mat_t mat, input byte_t v);
        byte_t acc;
        acc = '0;
        for (int b = 0; b < SHARD_W; b++)
        begin
            if (v[b])
            begin
                acc = acc ^ mat[SHARD_W*b +: SHARD_W];
            end
        end
        return acc;
    endfunction

    // layer one: pairs (0,1) (2,3) (4,5) (6,7), one matrix each
    function automatic shard_vec_t layer_one(input shard_vec_t v, input mat_t m01,
                                             input mat_t m23, input mat_t m45,
                                             input mat_t m67);
        shard_vec_t r;
        r    = v;
        r[1] = v[1] ^ v[0];
        r[0] = v[0] ^ gf2_matmul(m01, r[1]);
        r[3] = v[3] ^ v[2];
        r[2] = v[2] ^ gf2_matmul(m23, r[3]);
        r[5] = v[5] ^ v[4];
        r[4] = v[4] ^ gf2_matmul(m45, r[5]);
        r[7] = v[7] ^ v[6];
        r[6] = v[6] ^ gf2_matmul(m67, r[7]);
        return r;
    endfunction

    // layer two: pairs (0,2) (1,3) under low, (4,6) (5,7) under high
    function automatic shard_vec_t layer_two(input shard_vec_t v, input mat_t mlo,
                                             input mat_t mhi);
        shard_vec_t r;
        r    = v;
        r[2] = v[2] ^ v[0];
        r[0] = v[0] ^ gf2_matmul(mlo, r[2]);
        r[3] = v[3] ^ v[1];
        r[1] = v[1] ^ gf2_matmul(mlo, r[3]);
        r[6] = v[6] ^ v[4];
        r[4] = v[4] ^ gf2_matmul(mhi, r[6]);
        r[7] = v[7] ^ v[5];
        r[5] = v[5] ^ gf2_matmul(mhi, r[7]);
        return r;
    endfunction

    // layer three: pairs (i, i+4) under one shared matrix
    function automatic shard_vec_t layer_three(input shard_vec_t v, input mat_t mt);
        shard_vec_t r;
        r = v;
        for (int i = 0; i < NUM_SHARD/2; i++)
        begin
            r[i+NUM_SHARD/2] = v[i+NUM_SHARD/2] ^ v[i];
            r[i]             = v[i] ^ gf2_matmul(mt, r[i+NUM_SHARD/2]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/gf256_radix8_butterfly_top.sv
// gf256_radix8_butterfly_top: three-stage pipeline, one butterfly layer per stage,
// plus the seven matrix configuration registers; depends on gf8bf_pkg
// pipeline: 3 register stages (s1, s2, s3); out_valid is the s3 valid register
// throughput: one item per cycle while out_stall is low; a stage advances when empty or when the next moves
// a waiting result stalls the input only once all three stages hold items
// reset: all matrices clear to zero and the pipeline empties
`default_nettype none

module gf256_radix8_butterfly_top
    import gf8bf_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    // configuration write port
    input  wire                  wr_en,
    input  wire [CFG_IDX_W-1:0]  wr_idx,
    input  wire [MAT_W-1:0]      wr_data,
    // input channel
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire [SHARD_W-1:0]    shard_in_0,
    input  wire [SHARD_W-1:0]    shard_in_1,
    input  wire [SHARD_W-1:0]    shard_in_2,
    input  wire [SHARD_W-1:0]    shard_in_3,
    input  wire [SHARD_W-1:0]    shard_in_4,
    input  wire [SHARD_W-1:0]    shard_in_5,
    input  wire [SHARD_W-1:0]    shard_in_6,
    input  wire [SHARD_W-1:0]    shard_in_7,
    input  wire                  final_in,
    // output channel
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic [SHARD_W-1:0]   shard_out_0,
    output logic [SHARD_W-1:0]   shard_out_1,
    output logic [SHARD_W-1:0]   shard_out_2,
    output logic [SHARD_W-1:0]   shard_out_3,
    output logic [SHARD_W-1:0]   shard_out_4,
    output logic [SHARD_W-1:0]   shard_out_5,
    output logic [SHARD_W-1:0]   shard_out_6,
    output logic [SHARD_W-1:0]   shard_out_7,
    output logic                 final_out
);

    mat_t mat_pair01_reg, mat_pair23_reg, mat_pair45_reg, mat_pair67_reg;
    mat_t mat_mid_low_reg, mat_mid_high_reg, mat_top_reg;

    shard_vec_t in_vec;
    shard_vec_t s1_data_reg, s2_data_reg, s3_data_reg;
    logic       s1_final_reg, s2_final_reg, s3_final_reg;
    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic       s1_adv, s2_adv, s3_adv;

    // matrix registers, indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_pair01_reg   <= '0;
            mat_pair23_reg   <= '0;
            mat_pair45_reg   <= '0;
            mat_pair67_reg   <= '0;
            mat_mid_low_reg  <= '0;
            mat_mid_high_reg <= '0;
            mat_top_reg      <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_PAIR01:   mat_pair01_reg   <= wr_data;
                REG_PAIR23:   mat_pair23_reg   <= wr_data;
                REG_PAIR45:   mat_pair45_reg   <= wr_data;
                REG_PAIR67:   mat_pair67_reg   <= wr_data;
                REG_MID_LOW:  mat_mid_low_reg  <= wr_data;
                REG_MID_HIGH: mat_mid_high_reg <= wr_data;
                REG_TOP:      mat_top_reg      <= wr_data;
                default:      ;
            endcase
        end
    end

    // gather the input bytes
    assign in_vec = {shard_in_7, shard_in_6, shard_in_5, shard_in_4,
                     shard_in_3, shard_in_2, shard_in_1, shard_in_0};

    // stage load enables: a stage loads when empty or when it drains downstream
    assign s3_adv   = !s3_valid_reg || !out_stall;
    assign s2_adv   = !s2_valid_reg || s3_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = !s1_adv;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // datapath: one butterfly layer per stage
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_data_reg  <= layer_one(in_vec, mat_pair01_reg, mat_pair23_reg,
                                      mat_pair45_reg, mat_pair67_reg);
            s1_final_reg <= final_in;
        end
        if (s2_adv)
        begin
            s2_data_reg  <= layer_two(s1_data_reg, mat_mid_low_reg, mat_mid_high_reg);
            s2_final_reg <= s1_final_reg;
        end
        if (s3_adv)
        begin
            s3_data_reg  <= layer_three(s2_data_reg, mat_top_reg);
            s3_final_reg <= s2_final_reg;
        end
    end

    // output ports
    assign out_valid   = s3_valid_reg;
    assign shard_out_0 = s3_data_reg[0];
    assign shard_out_1 = s3_data_reg[1];
    assign shard_out_2 = s3_data_reg[2];
    assign shard_out_3 = s3_data_reg[3];
    assign shard_out_4 = s3_data_reg[4];
    assign shard_out_5 = s3_data_reg[5];
    assign shard_out_6 = s3_data_reg[6];
    assign shard_out_7 = s3_data_reg[7];
    assign final_out   = s3_final_reg;

endmodule

`default_nettype wire
